// File: rtl/core/b64enc_pkg.sv
`timescale 1ns / 1ps
package b64enc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned WordW  = 3 * ByteW;
  localparam int unsigned JobQD  = 2;
  localparam int unsigned JobQAw = $clog2(JobQD);
  localparam int unsigned JobQCw = $clog2(JobQD + 1);

  localparam logic [CharW-1:0] PadChar = 7'h3d;

  // Number of '=' characters that close a job.
  typedef enum logic [1:0] {
    PAD_NONE = 2'd0,
    PAD_ONE  = 2'd1,
    PAD_TWO  = 2'd2
  } pad_t;

  // One group of up to three bytes, ready to be turned into four characters.
  typedef struct packed {
    logic [WordW-1:0] word;
    pad_t             pad;
    logic             last;
  } job_t;

  // Status of the job queue between the front and back parts.
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [JobQCw-1:0] count;
  } jobq_stat_t;

  function automatic logic [CharW-1:0] b64_char(input logic [5:0] idx);
    logic [CharW-1:0] c;
    if (idx < 6'd26) begin
      c = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      c = 7'h61 + {1'b0, idx - 6'd26};
    end else if (idx < 6'd62) begin
      c = 7'h30 + {1'b0, idx - 6'd52};
    end else if (idx == 6'd62) begin
      c = 7'h2b;
    end else begin
      c = 7'h2f;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/base64_stream_encoder_core.sv
`timescale 1ns / 1ps
// A group is registered in the job queue, then each character in the output register.
// Throughput: one byte per cycle in while the queue has room, one character per cycle
//   out while popped; each group gives four characters, so the back part sets the pace.
// Reset: rst_n is synchronous, active low; it empties the job queue and output register
//   and clears the group count. Held bytes keep their contents.
module base64_stream_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_message,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [6:0] out_char,
  output logic       out_last_char
);
  import b64enc_pkg::*;

  logic       in_accept;
  logic       job_push;
  job_t       push_job;
  job_t       head_job;
  logic       job_pop;
  jobq_stat_t q_stat;

  // Stall the input side only when the job queue cannot take another group.
  // A byte that merely fills a hold slot also waits then; that keeps the
  // accept condition simple and costs nothing once the back part drains.
  assign in_full   = q_stat.full;
  assign in_accept = in_push && !in_full;

  // Front: gather bytes into groups and classify how each group ends.
  b64enc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .job_push          (job_push),
    .job               (push_job)
  );

  // Short queue between the two parts so each can stall on its own.
  b64enc_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  // Back: spell each group out one character per beat into the output register.
  b64enc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_avail     (!q_stat.empty),
    .job           (head_job),
    .job_pop       (job_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

  // Queue occupancy never runs past its depth.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= JobQCw'(JobQD))
    else $error("job queue overflow");

  // The back part retires a job only when one is waiting.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !q_stat.empty)
    else $error("job popped from empty queue");

  // A group is never produced while the queue is full: input is stalled then.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !q_stat.full)
    else $error("job pushed into full queue");

  // A character shown and not taken stays on the ports.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char) && $stable(out_last_char)))
    else $error("output changed while waiting");

endmodule

// File: rtl/core/b64enc_front.sv
`timescale 1ns / 1ps
module b64enc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_accept,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_end_of_message,
  output logic                      job_push,
  output b64enc_pkg::job_t          job
);
  import b64enc_pkg::*;

  logic [1:0]       group_count_r, group_count_nxt;
  logic [ByteW-1:0] held_r [2];

  always_comb begin
    group_count_nxt = group_count_r;
    job_push        = 1'b0;
    job.word        = {held_r[0], held_r[1], in_data_byte};
    job.pad         = PAD_NONE;
    job.last        = in_end_of_message;
    if (in_accept) begin
      if (group_count_r >= 2'd2) begin
        job_push        = 1'b1;
        group_count_nxt = 2'd0;
      end else if (!in_end_of_message) begin
        group_count_nxt = group_count_r + 2'd1;
      end else begin
        job_push        = 1'b1;
        group_count_nxt = 2'd0;
        if (group_count_r == 2'd0) begin
          job.word = {in_data_byte, {(2 * ByteW){1'b0}}};
          job.pad  = PAD_TWO;
        end else begin
          job.word = {held_r[0], in_data_byte, {ByteW{1'b0}}};
          job.pad  = PAD_ONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_count_r <= 2'd0;
    end else begin
      group_count_r <= group_count_nxt;
    end
  end

  // Hold the byte in its slot while the group is still open.
  always_ff @(posedge clk) begin
    if (in_accept && !in_end_of_message && group_count_r < 2'd2) begin
      held_r[group_count_r[0]] <= in_data_byte;
    end
  end

endmodule

// File: rtl/core/b64enc_jobq.sv
`timescale 1ns / 1ps
module b64enc_jobq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  b64enc_pkg::job_t          push_job,
  input  logic                      pop,
  output b64enc_pkg::job_t          head_job,
  output b64enc_pkg::jobq_stat_t    stat
);
  import b64enc_pkg::*;

  job_t              mem [JobQD];
  logic [JobQAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [JobQCw-1:0] count_r;
  logic              do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == JobQCw'(JobQD));
  assign stat.count = count_r;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + JobQAw'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + JobQAw'(1);
      count_r <= count_r + JobQCw'(do_push) - JobQCw'(do_pop);
    end
  end

endmodule

// File: rtl/core/b64enc_back.sv
`timescale 1ns / 1ps
module b64enc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      job_avail,
  input  b64enc_pkg::job_t          job,
  output logic                      job_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [6:0]                out_char,
  output logic                      out_last_char
);
  import b64enc_pkg::*;

  logic [1:0]       idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [CharW-1:0] char_r;
  logic             last_r;
  logic             load;
  logic [5:0]       sextet;
  logic [CharW-1:0] char_nxt;
  logic             is_pad;

  // Load a new character whenever a job waits and the output register is free or drains now.
  assign load    = job_avail && (!valid_r || out_pop);
  assign job_pop = load && (idx_r == 2'd3);

  always_comb begin
    case (idx_r)
      2'd0:    sextet = job.word[23:18];
      2'd1:    sextet = job.word[17:12];
      2'd2:    sextet = job.word[11:6];
      default: sextet = job.word[5:0];
    endcase
    case (job.pad)
      PAD_TWO: is_pad = (idx_r >= 2'd2);
      PAD_ONE: is_pad = (idx_r == 2'd3);
      default: is_pad = 1'b0;
    endcase
    char_nxt  = is_pad ? PadChar : b64_char(sextet);
    idx_nxt   = load ? idx_r + 2'd1 : idx_r;
    valid_nxt = load || (valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      last_r <= job.last && (idx_r == 2'd3);
    end
  end

  assign out_empty     = !valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;

endmodule
